// File: rtl/core/itoa_pkg.sv
package itoa_pkg;

  localparam int MAX_FIELD_DEF = 60;
  localparam int SEG_COUNT     = 7;

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [2:0] SC_CHAR  = 3'd0;
  localparam logic [2:0] SC_SHORT = 3'd1;
  localparam logic [2:0] SC_INT   = 3'd2;
  localparam logic [2:0] SC_PDIFF = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  radix_code;
    logic [2:0]  size_class;
    logic        is_signed;
    logic        zero_pad;
    logic        left_justify;
    logic        plus_sign;
    logic        space_sign;
    logic        alternate_form;
    logic        upper_digits;
    logic [5:0]  min_width;
    logic [5:0]  min_digits;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } fmt_res_t;

  // output field segments, in emission order
  typedef enum logic [2:0] {
    SEG_ZPRE = 3'd0,
    SEG_LPAD = 3'd1,
    SEG_OCT  = 3'd2,
    SEG_PRE  = 3'd3,
    SEG_SIGN = 3'd4,
    SEG_DIG  = 3'd5,
    SEG_RPAD = 3'd6
  } seg_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic size_calc;
    logic seg_load;
    seg_t load_seg;
    logic emit;
    seg_t emit_seg;
    logic last;
  } itoa_cmd_t;

  typedef struct packed {
    logic                 conv_last;
    logic                 cnt_last;
    logic [SEG_COUNT-1:0] seg_nz;
  } itoa_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + 8'(d);
    end else begin
      c = (upper ? CH_UA : CH_LA) + 8'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// File: rtl/core/itoa_ctrl.sv
module itoa_ctrl import itoa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  itoa_stat_t stat,
  output itoa_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SIZE  = 5'b00100,
    ST_FIRST = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  seg_t   seg_r, seg_nxt;

  // lowest non-empty segment at or above lo: {found, code}
  function automatic logic [3:0] seg_from(input logic [SEG_COUNT-1:0] nz,
                                          input logic [3:0] lo);
    logic       found;
    logic [2:0] code;
    found = 1'b0;
    code  = 3'd0;
    for (int i = 0; i < SEG_COUNT; i++) begin
      if (nz[i] && (4'(i) >= lo) && !found) begin
        found = 1'b1;
        code  = 3'(i);
      end
    end
    return {found, code};
  endfunction

  logic [3:0] first_seg;
  logic [3:0] next_seg;

  assign first_seg = seg_from(stat.seg_nz, 4'd0);
  assign next_seg  = seg_from(stat.seg_nz, {1'b0, seg_r} + 4'd1);
  assign busy      = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    cmd       = '0;
    cmd.emit_seg = seg_r;
    cmd.load_seg = seg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_last) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd.size_calc = 1'b1;
        state_nxt     = ST_FIRST;
      end
      ST_FIRST: begin
        cmd.seg_load = 1'b1;
        cmd.load_seg = seg_t'(first_seg[2:0]);
        seg_nxt      = seg_t'(first_seg[2:0]);
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.cnt_last) begin
          if (next_seg[3]) begin
            cmd.seg_load = 1'b1;
            cmd.load_seg = seg_t'(next_seg[2:0]);
            seg_nxt      = seg_t'(next_seg[2:0]);
          end else begin
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seg_r   <= SEG_ZPRE;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
    end
  end

endmodule

// File: rtl/core/itoa_dpath.sv
module itoa_dpath import itoa_pkg::*; #(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  fmt_req_t   in_req,
  input  itoa_cmd_t  cmd,
  output itoa_stat_t stat,
  output logic       out_valid,
  output fmt_res_t   out_res
);

  logic [31:0] mag_r;
  logic        has_sign_r;
  logic [7:0]  sign_ch_r;
  logic [1:0]  radix_r;
  logic        zp_r;
  logic        left_r;
  logic        alt_r;
  logic        upper_r;
  logic [5:0]  width_r;
  logic [5:0]  prec_r;
  logic [39:0] bcd_r;
  logic [4:0]  bit_idx_r;
  logic        found_r;
  logic [4:0]  pos_r;
  logic [5:0]  nat_r;
  logic [5:0]  cnt_r;
  logic        out_valid_r;
  fmt_res_t    out_res_r;

  // sign and magnitude at intake
  logic        neg;
  logic [31:0] mag_in;
  logic [7:0]  sign_in;
  logic        sgn_in;

  always_comb begin
    neg    = 1'b0;
    mag_in = in_req.value;
    if (in_req.is_signed) begin
      case (in_req.size_class) inside
        SC_CHAR: begin
          if (in_req.value[7]) begin
            neg    = 1'b1;
            mag_in = {23'd0, 9'(9'h100 - {1'b0, in_req.value[7:0]})};
          end
        end
        SC_SHORT: begin
          if (in_req.value[15]) begin
            neg    = 1'b1;
            mag_in = {15'd0, 17'(17'h10000 - {1'b0, in_req.value[15:0]})};
          end
        end
        SC_INT, SC_PDIFF: begin
          if (in_req.value[31]) begin
            neg    = 1'b1;
            mag_in = 32'd0 - in_req.value;
          end
        end
        default: begin
          neg = 1'b0;
        end
      endcase
    end
    sgn_in  = neg || in_req.space_sign || in_req.plus_sign;
    sign_in = neg ? CH_MINUS : (in_req.space_sign ? CH_SPACE : CH_PLUS);
  end

  // shift-and-add-3 step
  logic [39:0] bcd_adj;

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                    : bcd_r[i*4 +: 4];
    end
  end

  // natural digit count
  logic [5:0] nat_dec;
  logic [5:0] nat_pow;
  logic [9:0] pos_x11;

  assign pos_x11 = 10'(pos_r) * 10'd11;

  always_comb begin
    nat_dec = 6'd1;
    for (int i = 1; i < 10; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        nat_dec = 6'(i + 1);
      end
    end
    case (radix_r)
      RADIX_BIN: nat_pow = 6'(pos_r) + 6'd1;
      RADIX_OCT: nat_pow = 6'(pos_x11[9:5]) + 6'd1;
      default:   nat_pow = 6'(pos_r[4:2]) + 6'd1;
    endcase
    if (!found_r) begin
      nat_pow = 6'd1;
    end
  end

  // segment lengths
  logic       two_pref;
  logic       oct_pref;
  logic [5:0] nd;
  logic [6:0] content;
  logic [5:0] pad;
  logic [5:0] seg_len [SEG_COUNT];

  always_comb begin
    two_pref = alt_r && (radix_r == RADIX_HEX || radix_r == RADIX_BIN);
    oct_pref = alt_r && (radix_r == RADIX_OCT);
    nd       = (nat_r > prec_r) ? nat_r : prec_r;
    content  = 7'(nd) + 7'(has_sign_r) + ((two_pref && !zp_r) ? 7'd2 : 7'd0)
             + 7'(oct_pref);
    pad      = ({1'b0, width_r} > content) ? 6'(7'(width_r) - content) : 6'd0;
    seg_len[SEG_ZPRE] = (two_pref && zp_r) ? 6'd2 : 6'd0;
    seg_len[SEG_LPAD] = left_r ? 6'd0 : pad;
    seg_len[SEG_OCT]  = 6'(oct_pref);
    seg_len[SEG_PRE]  = (two_pref && !zp_r) ? 6'd2 : 6'd0;
    seg_len[SEG_SIGN] = 6'(has_sign_r);
    seg_len[SEG_DIG]  = nd;
    seg_len[SEG_RPAD] = left_r ? pad : 6'd0;
  end

  always_comb begin
    for (int i = 0; i < SEG_COUNT; i++) begin
      stat.seg_nz[i] = (seg_len[i] != 6'd0);
    end
    stat.conv_last = (bit_idx_r == 5'd0);
    stat.cnt_last  = (cnt_r == 6'd1);
  end

  // character selection
  logic [5:0]  dig_idx;
  logic [7:0]  sh;
  logic [31:0] pow_sh;
  logic [39:0] dec_sh;
  logic [3:0]  dig;
  logic [7:0]  ch;
  logic [7:0]  pref_ch;

  always_comb begin
    dig_idx = cnt_r - 6'd1;
    case (radix_r)
      RADIX_BIN: sh = 8'(dig_idx);
      RADIX_OCT: sh = 8'(dig_idx) * 8'd3;
      default:   sh = 8'(dig_idx) << 2;
    endcase
    pow_sh = mag_r >> sh;
    dec_sh = bcd_r >> (8'(dig_idx) << 2);
    case (radix_r)
      RADIX_BIN: dig = {3'd0, pow_sh[0]};
      RADIX_OCT: dig = {1'b0, pow_sh[2:0]};
      RADIX_DEC: dig = dec_sh[3:0];
      default:   dig = pow_sh[3:0];
    endcase
    pref_ch = (cnt_r == 6'd2) ? CH_ZERO : ((radix_r == RADIX_HEX) ? CH_X : CH_B);
    unique case (cmd.emit_seg)
      SEG_ZPRE: ch = pref_ch;
      SEG_LPAD: ch = zp_r ? CH_ZERO : CH_SPACE;
      SEG_OCT:  ch = CH_ZERO;
      SEG_PRE:  ch = pref_ch;
      SEG_SIGN: ch = sign_ch_r;
      SEG_DIG:  ch = digit_char(dig, upper_r);
      SEG_RPAD: ch = CH_SPACE;
      default:  ch = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r      <= mag_in;
      has_sign_r <= sgn_in;
      sign_ch_r  <= sign_in;
      radix_r    <= in_req.radix_code;
      left_r     <= in_req.left_justify;
      zp_r       <= in_req.zero_pad && !in_req.left_justify;
      alt_r      <= in_req.alternate_form;
      upper_r    <= in_req.upper_digits;
      width_r    <= (in_req.min_width > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : in_req.min_width;
      prec_r     <= (in_req.min_digits > 6'(MAX_FIELD)) ? 6'(MAX_FIELD)
                                                        : in_req.min_digits;
      bcd_r      <= '0;
      bit_idx_r  <= 5'd31;
      found_r    <= 1'b0;
      pos_r      <= 5'd0;
    end else if (cmd.conv_step) begin
      bcd_r     <= {bcd_adj[38:0], mag_r[bit_idx_r]};
      bit_idx_r <= bit_idx_r - 5'd1;
      if (mag_r[bit_idx_r] && !found_r) begin
        found_r <= 1'b1;
        pos_r   <= bit_idx_r;
      end
    end
    if (cmd.size_calc) begin
      nat_r <= (radix_r == RADIX_DEC) ? nat_dec : nat_pow;
    end
    if (cmd.seg_load) begin
      cnt_r <= seg_len[cmd.load_seg];
    end else if (cmd.emit) begin
      cnt_r <= cnt_r - 6'd1;
    end
    if (cmd.emit) begin
      out_res_r.char_code <= ch;
      out_res_r.last_char <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// File: rtl/core/integer_to_ascii_formatter.sv
// Formats one 32-bit integer per request as ASCII, most significant character first.
// A request is taken when start is high and busy is low. The value then walks through a
// shift-and-add-3 converter one bit per cycle, the field is then sized and the first
// segment picked, after which one character leaves per cycle on out_res with out_valid
// high for that cycle alone; the final character has last_char set. A request yielding
// 1 to 63 characters holds busy until its final character is emitted, and no new request
// is taken before then. There is no backpressure: the receiver must take every beat.
module integer_to_ascii_formatter import itoa_pkg::*; #(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  fmt_req_t in_req,
  output logic     out_valid,
  output fmt_res_t out_res
);

  itoa_cmd_t  cmd;
  itoa_stat_t stat;

  itoa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  itoa_dpath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

`ifndef NO_ASSERTIONS
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.last_char |-> !busy)
    else $error("busy still high after last beat");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_no_early_beat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("beat right after accept");

  a_beat_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("beat without a request in flight");
`endif

endmodule
